### rtl/ptw_pkg.sv
// Shared types, widths and codes of the four-level page table walker.
package ptw_pkg;

   localparam int TABLE_WORDS_DEF = 4096;

   localparam int VA_W     = 48;
   localparam int PA_W     = 48;
   localparam int FRAME_W  = 36;
   localparam int ENTRY_W  = 64;
   localparam int WIDX_W   = 12;
   localparam int LEFT_W   = 31;
   localparam int TIDX_W   = 9;
   localparam int CODE_W   = 2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   // Register index as seen in the address bit above the 8-byte offset.
   localparam logic CSR_IDX_ROOT = 1'b0;

   localparam logic CMD_WRITE     = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

   localparam logic [CODE_W-1:0] LEVEL_PML4 = 2'd0;
   localparam logic [CODE_W-1:0] LEVEL_PDPT = 2'd1;
   localparam logic [CODE_W-1:0] LEVEL_PD   = 2'd2;
   localparam logic [CODE_W-1:0] LEVEL_PT   = 2'd3;

   localparam logic [CODE_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [CODE_W-1:0] STATUS_NOT_PRESENT = 2'd1;
   localparam logic [CODE_W-1:0] STATUS_OUTSIDE     = 2'd2;

   localparam logic [CODE_W-1:0] PAGE_4K = 2'd0;
   localparam logic [CODE_W-1:0] PAGE_2M = 2'd1;
   localparam logic [CODE_W-1:0] PAGE_1G = 2'd2;

   localparam logic [LEFT_W-1:0] SIZE_1G = LEFT_W'(64'h4000_0000);
   localparam logic [LEFT_W-1:0] SIZE_2M = LEFT_W'(64'h0020_0000);
   localparam logic [LEFT_W-1:0] SIZE_4K = LEFT_W'(64'h0000_1000);

   localparam int ENTRY_PRESENT_BIT = 0;
   localparam int ENTRY_LARGE_BIT   = 7;

   typedef struct packed {
      logic [PA_W-1:0]   physical_address;
      logic [LEFT_W-1:0] bytes_left_in_page;
      logic [CODE_W-1:0] page_size_code;
      logic [CODE_W-1:0] status;
      logic [CODE_W-1:0] fault_level;
   } result_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_EVAL,
      ST_FINISH
   } state_type;

endpackage

### rtl/ptw_req_if.sv
// Request channel of the page table walker: valid/ready plus the command fields.
interface ptw_req_if
   import ptw_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                command;
   logic [WIDX_W-1:0]   table_word_index;
   logic [ENTRY_W-1:0]  table_word_data;
   logic [VA_W-1:0]     virtual_address;

   modport source (
      output valid, command, table_word_index, table_word_data, virtual_address,
      input  ready
   );

   modport sink (
      input  valid, command, table_word_index, table_word_data, virtual_address,
      output ready
   );
endinterface

### rtl/ptw_rsp_if.sv
// Response channel of the page table walker: valid/ready plus the result fields.
interface ptw_rsp_if
   import ptw_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [PA_W-1:0]     physical_address;
   logic [LEFT_W-1:0]   bytes_left_in_page;
   logic [CODE_W-1:0]   page_size_code;
   logic [CODE_W-1:0]   status;
   logic [CODE_W-1:0]   fault_level;

   modport source (
      output valid, physical_address, bytes_left_in_page, page_size_code, status,
             fault_level,
      input  ready
   );

   modport sink (
      input  valid, physical_address, bytes_left_in_page, page_size_code, status,
             fault_level,
      output ready
   );
endinterface

### rtl/four_level_page_table_walker.sv
// Four-level page table walker: sequencer, configuration register and response stage.
//
// Requests arrive on req_chan (valid/ready). A write command stores one 64-bit
// table word; a translate command walks PML4, PDPT, PD and PT through the
// internal table store, stopping early on 1 GB and 2 MB pages or on a fault.
// Every request gives exactly one response on rsp_chan (valid/ready).
// The root table frame is set through the APB-style csr_ port at byte address 0.
//
// A write goes from acceptance straight to the response stage. A translation has an
// issue step, one table read per level (none to four, through the single read
// port of the table store) and a step to load the response register, so a 4 KB
// walk reads all four levels. No new request is taken while one is in progress;
// the next one is taken the cycle after the response register is loaded.
//
// After reset the table store is swept to zero, one word per cycle; no request
// is accepted meanwhile, but configuration writes are. A stalled receiver holds
// the response; one further request may be accepted and processed, and it then
// waits until the response slot frees.
module four_level_page_table_walker
   import ptw_pkg::*;
#(
   parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ptw_req_if.sink               req_chan,
   ptw_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ADDR_W = $clog2(TABLE_WORDS);

   state_type          state_ff, state_in;
   logic [CODE_W-1:0]  level_ff, level_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [VA_W-1:0]    va_ff, va_in;
   result_type         res_ff, res_in;
   result_type         rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0] root_ff, root_in;

   logic               req_ready;
   logic               req_accept;
   logic               rsp_slot_free;
   logic               widx_in_range;
   logic               csr_write;

   logic               clear_busy;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   logic [FRAME_W-1:0] step_frame;
   logic [CODE_W-1:0]  step_level;
   logic [ADDR_W-1:0]  step_addr;
   logic               step_in_range;

   logic               entry_present;
   logic               entry_large;
   logic               eval_stop;
   result_type         eval_res;

   ptw_table_store #(
      .TABLE_WORDS (TABLE_WORDS),
      .ADDR_W      (ADDR_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   ptw_step_unit #(
      .TABLE_WORDS (TABLE_WORDS),
      .ADDR_W      (ADDR_W)
   ) u_step (
      .frame           (step_frame),
      .virtual_address (va_ff),
      .level           (step_level),
      .word_addr       (step_addr),
      .in_range        (step_in_range)
   );

   // Configuration port.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_ROOT) ?
                       CSR_DATA_W'(root_ff) : '0;

   always_comb begin
      root_in = root_ff;
      if (csr_write && csr_paddr[CSR_ADDR_W-1] == CSR_IDX_ROOT) begin
         root_in = csr_pwdata[FRAME_W-1:0];
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_accept    = req_chan.valid && req_ready;
   assign rsp_slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign widx_in_range = 32'(req_chan.table_word_index) < 32'(TABLE_WORDS);

   // The step unit forms the first address from the latched frame and every
   // later one straight from the entry just read, so one read issues per cycle.
   assign step_frame = (state_ff == ST_EVAL) ? rd_data[47:12] : frame_ff;
   assign step_level = (state_ff == ST_EVAL) ? level_ff + 2'd1 : level_ff;

   assign entry_present = rd_data[ENTRY_PRESENT_BIT];
   assign entry_large   = rd_data[ENTRY_LARGE_BIT];

   // Outcome of the entry read at the current level.
   always_comb begin
      eval_res  = '0;
      eval_stop = 1'b1;
      if (!entry_present) begin
         eval_res.status      = STATUS_NOT_PRESENT;
         eval_res.fault_level = level_ff;
      end else if (level_ff == LEVEL_PDPT && entry_large) begin
         eval_res.physical_address   = {rd_data[47:30], va_ff[29:0]};
         eval_res.bytes_left_in_page = SIZE_1G - LEFT_W'(va_ff[29:0]);
         eval_res.page_size_code     = PAGE_1G;
      end else if (level_ff == LEVEL_PD && entry_large) begin
         eval_res.physical_address   = {rd_data[47:21], va_ff[20:0]};
         eval_res.bytes_left_in_page = SIZE_2M - LEFT_W'(va_ff[20:0]);
         eval_res.page_size_code     = PAGE_2M;
      end else if (level_ff == LEVEL_PT) begin
         eval_res.physical_address   = {rd_data[47:12], va_ff[11:0]};
         eval_res.bytes_left_in_page = SIZE_4K - LEFT_W'(va_ff[11:0]);
         eval_res.page_size_code     = PAGE_4K;
      end else if (!step_in_range) begin
         eval_res.status      = STATUS_OUTSIDE;
         eval_res.fault_level = level_ff + 2'd1;
      end else begin
         eval_stop = 1'b0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (!clear_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_chan.command == CMD_TRANSLATE) ? ST_ISSUE : ST_FINISH;
            end
         end
         ST_ISSUE: begin
            state_in = step_in_range ? ST_EVAL : ST_FINISH;
         end
         ST_EVAL: begin
            if (eval_stop) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      level_in     = level_ff;
      frame_in     = frame_ff;
      va_in        = va_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rd_en        = 1'b0;
      rd_addr      = step_addr;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(req_chan.table_word_index);
      wr_data      = req_chan.table_word_data;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               va_in    = req_chan.virtual_address;
               frame_in = root_ff;
               level_in = LEVEL_PML4;
               res_in   = '0;
               wr_en    = (req_chan.command == CMD_WRITE) && widx_in_range;
            end
         end
         ST_ISSUE: begin
            if (step_in_range) begin
               rd_en = 1'b1;
            end else begin
               res_in.status      = STATUS_OUTSIDE;
               res_in.fault_level = level_ff;
            end
         end
         ST_EVAL: begin
            if (eval_stop) begin
               res_in = eval_res;
            end else begin
               rd_en    = 1'b1;
               level_in = level_ff + 2'd1;
            end
         end
         ST_FINISH: begin
            if (rsp_slot_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         root_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         root_ff      <= root_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      frame_ff <= frame_in;
      va_ff    <= va_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_chan.ready              = req_ready;
   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.physical_address   = rsp_ff.physical_address;
   assign rsp_chan.bytes_left_in_page = rsp_ff.bytes_left_in_page;
   assign rsp_chan.page_size_code     = rsp_ff.page_size_code;
   assign rsp_chan.status             = rsp_ff.status;
   assign rsp_chan.fault_level        = rsp_ff.fault_level;

   a_read_in_range: assert property (
      @(posedge clock) disable iff (reset) rd_en |-> step_in_range
   ) else $error("table read issued outside the table store");

   a_no_request_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clear_busy |-> !req_ready
   ) else $error("request accepted during the clearing pass");

   a_ok_has_no_level: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_OK) |-> rsp_ff.fault_level == LEVEL_PML4
   ) else $error("fault level set on a successful response");

   a_fault_has_no_address: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != STATUS_OK) |->
         (rsp_ff.physical_address == '0 && rsp_ff.bytes_left_in_page == '0)
   ) else $error("faulting response carries an address");

endmodule

### rtl/ptw_table_store.sv
// Table word memory with one write port, one registered read port and a clearing pass.
module ptw_table_store
   import ptw_pkg::*;
#(
   parameter int TABLE_WORDS = TABLE_WORDS_DEF,
   parameter int ADDR_W      = $clog2(TABLE_WORDS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [ENTRY_W-1:0] rd_data,
   output logic               clear_busy
);

   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(TABLE_WORDS - 1);

   logic [ENTRY_W-1:0] mem [TABLE_WORDS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               clear_busy_ff, clear_busy_in;
   logic [ADDR_W-1:0]  clear_cnt_ff, clear_cnt_in;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   // After reset every word is swept to zero, one per cycle.
   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_cnt_in  = clear_cnt_ff;
      if (clear_busy_ff) begin
         clear_cnt_in = clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == LAST_WORD) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      mem_we    = wr_en;
      mem_waddr = wr_addr;
      mem_wdata = wr_data;
      if (clear_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clear_cnt_ff;
         mem_wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_cnt_ff  <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_cnt_ff  <= clear_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clear_busy_ff;

   a_no_write_while_clearing: assert property (
      @(posedge clock) disable iff (reset) wr_en |-> !clear_busy_ff
   ) else $error("table write requested during the clearing pass");

   a_clear_covers_all: assert property (
      @(posedge clock) disable iff (reset)
      $fell(clear_busy_ff) |-> $past(clear_cnt_ff) == LAST_WORD
   ) else $error("clearing pass ended before the last word");

endmodule

### rtl/ptw_step_unit.sv
// Shared per-level address unit: picks the table index and bounds-checks the word address.
module ptw_step_unit
   import ptw_pkg::*;
#(
   parameter int TABLE_WORDS = TABLE_WORDS_DEF,
   parameter int ADDR_W      = $clog2(TABLE_WORDS)
) (
   input  logic [FRAME_W-1:0] frame,
   input  logic [VA_W-1:0]    virtual_address,
   input  logic [CODE_W-1:0]  level,
   output logic [ADDR_W-1:0]  word_addr,
   output logic               in_range
);

   localparam int WORD_W = FRAME_W + TIDX_W;

   logic [TIDX_W-1:0] tidx;
   logic [WORD_W-1:0] word;

   always_comb begin
      case (level)
         LEVEL_PML4: tidx = virtual_address[47:39];
         LEVEL_PDPT: tidx = virtual_address[38:30];
         LEVEL_PD:   tidx = virtual_address[29:21];
         LEVEL_PT:   tidx = virtual_address[20:12];
         default:    tidx = '0;
      endcase
   end

   assign word      = {frame, tidx};
   assign in_range  = word < WORD_W'(TABLE_WORDS);
   assign word_addr = word[ADDR_W-1:0];

endmodule

### test/testbench.sv
// Self-checking testbench of the four-level page table walker with its own table model.
`timescale 1ns / 100ps

module testbench
   import ptw_pkg::*;
();

   localparam real CLOCK_PERIOD = 12.0;
   localparam int  RESET_CYCLES = 9;
   localparam int  LIMIT_CYCLES = 400000;
   localparam int  TABLE_FRAMES = TABLE_WORDS_DEF / 512;
   localparam int  LONG_HOLD_AT = 700;
   localparam int  LONG_HOLD_CYCLES = 300;
   localparam int  DRAIN_CYCLES = 8;
   localparam logic [CSR_ADDR_W-1:0] ROOT_FRAME_ADDR = CSR_ADDR_W'({CSR_IDX_ROOT, 3'b000});
   localparam logic [CODE_W-1:0] WALK_LEVELS [4] = '{LEVEL_PML4, LEVEL_PDPT, LEVEL_PD, LEVEL_PT};

   typedef struct {
      logic               command;
      logic [WIDX_W-1:0]  word_index;
      logic [ENTRY_W-1:0] word_data;
      logic [VA_W-1:0]    vaddr;
   } walk_request_type;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ptw_req_if request_bus ();
   ptw_rsp_if response_bus ();

   four_level_page_table_walker u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (request_bus),
      .rsp_chan    (response_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   walk_request_type   request_backlog [$];
   result_type         expected_translations [$];
   logic [ENTRY_W-1:0] table_mirror [TABLE_WORDS_DEF];
   logic [FRAME_W-1:0] root_frame_mirror;
   int                 queued_items;
   int                 accepted_requests;
   int                 error_count;
   logic               quiet;
   logic               long_hold_done;
   int                 send_gap;
   int                 stall_left;

   // Applies one request to the table mirror and returns the response it must produce.
   function automatic result_type translate_or_store(input walk_request_type req);
      result_type                     r;
      logic [FRAME_W-1:0]             frame;
      logic [ENTRY_W-1:0]             entry;
      logic [FRAME_W+TIDX_W-1:0]      word;
      logic [TIDX_W-1:0]              idx;
      r = '0;
      if (req.command == CMD_WRITE) begin
         table_mirror[req.word_index] = req.word_data;
         return r;
      end
      frame = root_frame_mirror;
      for (int level = 0; level < 4; level++) begin
         idx = req.vaddr[(39 - 9 * level) +: TIDX_W];
         word = {frame, idx};
         if (word >= TABLE_WORDS_DEF) begin
            r.status = STATUS_OUTSIDE;
            r.fault_level = WALK_LEVELS[level];
            return r;
         end
         entry = table_mirror[word[WIDX_W-1:0]];
         if (!entry[ENTRY_PRESENT_BIT]) begin
            r.status = STATUS_NOT_PRESENT;
            r.fault_level = WALK_LEVELS[level];
            return r;
         end
         if (WALK_LEVELS[level] == LEVEL_PDPT && entry[ENTRY_LARGE_BIT]) begin
            r.physical_address = {entry[47:30], req.vaddr[29:0]};
            r.bytes_left_in_page = SIZE_1G - LEFT_W'(req.vaddr[29:0]);
            r.page_size_code = PAGE_1G;
            return r;
         end
         if (WALK_LEVELS[level] == LEVEL_PD && entry[ENTRY_LARGE_BIT]) begin
            r.physical_address = {entry[47:21], req.vaddr[20:0]};
            r.bytes_left_in_page = SIZE_2M - LEFT_W'(req.vaddr[20:0]);
            r.page_size_code = PAGE_2M;
            return r;
         end
         frame = entry[47:12];
      end
      r.physical_address = {frame, req.vaddr[11:0]};
      r.bytes_left_in_page = SIZE_4K - LEFT_W'(req.vaddr[11:0]);
      r.page_size_code = PAGE_4K;
      return r;
   endfunction

   // Fields a command does not use still carry random values.
   task automatic queue_write(input logic [WIDX_W-1:0] index, input logic [ENTRY_W-1:0] data);
      walk_request_type req;
      req.command = CMD_WRITE;
      req.word_index = index;
      req.word_data = data;
      req.vaddr = VA_W'({$urandom, $urandom});
      request_backlog.push_back(req);
      queued_items++;
   endtask

   task automatic queue_translate(input logic [VA_W-1:0] vaddr);
      walk_request_type req;
      req.command = CMD_TRANSLATE;
      req.word_index = WIDX_W'($urandom);
      req.word_data = {$urandom, $urandom};
      req.vaddr = vaddr;
      request_backlog.push_back(req);
      queued_items++;
   endtask

   function automatic logic [ENTRY_W-1:0] make_entry(input logic present, input logic large_page,
                                                     input logic [FRAME_W-1:0] frame);
      logic [ENTRY_W-1:0] e;
      e = {$urandom, $urandom};
      e[47:12] = frame;
      e[ENTRY_LARGE_BIT] = large_page;
      e[ENTRY_PRESENT_BIT] = present;
      return e;
   endfunction

   function automatic logic [FRAME_W-1:0] outside_frame();
      if ($urandom_range(0, 1))
         return FRAME_W'($urandom_range(TABLE_FRAMES, 2 * TABLE_FRAMES - 1));
      return FRAME_W'({$urandom, $urandom});
   endfunction

   // Builds one chain of entries from the root and translates addresses that follow it.
   // Most chains end in a 4 KB, 2 MB or 1 GB page; the rest are cut short by a missing
   // entry or by a pointer to a table outside the store.
   task automatic queue_walk(input logic [FRAME_W-1:0] root);
      logic [TIDX_W-1:0]  idx [4];
      logic [FRAME_W-1:0] frame;
      logic [FRAME_W-1:0] next;
      logic [29:0]        low;
      logic               present;
      logic               large_page;
      logic               broken;
      int                 outcome;
      int                 stop_level;
      foreach (idx[i]) idx[i] = TIDX_W'($urandom);
      outcome = $urandom_range(0, 99);
      broken = outcome >= 75;
      if (outcome < 40) stop_level = 3;
      else if (outcome < 60) stop_level = 2;
      else if (outcome < 75) stop_level = 1;
      else stop_level = $urandom_range(0, 3);
      frame = root;
      for (int level = 0; level <= stop_level; level++) begin
         present = 1'b1;
         large_page = (level == 0 || level == 3) ? 1'($urandom) : 1'b0;
         next = ($urandom_range(0, 9) != 0) ? FRAME_W'($urandom_range(0, TABLE_FRAMES - 1))
                                            : outside_frame();
         if (level == stop_level) begin
            if (broken) begin
               if (level == 3 || $urandom_range(0, 1)) begin
                  present = 1'b0;
                  large_page = 1'($urandom);
               end else begin
                  next = outside_frame();
               end
            end else begin
               large_page = (level == 1 || level == 2) ? 1'b1 : large_page;
               next = FRAME_W'({$urandom, $urandom});
            end
         end
         if ({frame, idx[level]} < TABLE_WORDS_DEF)
            queue_write(WIDX_W'({frame, idx[level]}), make_entry(present, large_page, next));
         frame = next;
      end
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(0, 3))
            0: low = '0;
            1: low = '1;
            default: low = 30'($urandom);
         endcase
         if (stop_level >= 2) low[29:21] = idx[2];
         if (stop_level == 3) low[20:12] = idx[3];
         queue_translate({idx[0], idx[1], low});
      end
   endtask

   task automatic queue_random_mix(input int item_total, input logic [FRAME_W-1:0] root);
      int first;
      first = queued_items;
      while (queued_items - first < item_total) begin
         if ($urandom_range(0, 9) < 7)
            queue_walk(root);
         else if ($urandom_range(0, 1))
            queue_write(WIDX_W'($urandom), {$urandom, $urandom});
         else
            queue_translate(VA_W'({$urandom, $urandom}));
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (request_backlog.size() != 0 || request_bus.valid ||
             expected_translations.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Upper data bits are random; only the low frame bits belong to the register.
   task automatic write_root_frame(input logic [FRAME_W-1:0] frame);
      logic [CSR_DATA_W-1:0] data;
      data = {$urandom, $urandom};
      data[FRAME_W-1:0] = frame;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ROOT_FRAME_ADDR;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      root_frame_mirror = frame;
   endtask

   always @(posedge clock) begin : drive_requests
      logic             next_valid;
      walk_request_type item;
      if (reset) begin
         request_bus.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         next_valid = request_bus.valid;
         if (request_bus.valid && request_bus.ready) begin
            item.command = request_bus.command;
            item.word_index = request_bus.table_word_index;
            item.word_data = request_bus.table_word_data;
            item.vaddr = request_bus.virtual_address;
            expected_translations.push_back(translate_or_store(item));
            accepted_requests <= accepted_requests + 1;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
            end else if (request_backlog.size() != 0) begin
               if (!quiet && $urandom_range(0, 5) == 0) begin
                  send_gap <= $urandom_range(0, 5);
               end else begin
                  item = request_backlog.pop_front();
                  request_bus.command <= item.command;
                  request_bus.table_word_index <= item.word_index;
                  request_bus.table_word_data <= item.word_data;
                  request_bus.virtual_address <= item.vaddr;
                  next_valid = 1'b1;
               end
            end
         end
         request_bus.valid <= next_valid;
      end
   end

   // The one long hold lets the walker fill up and back-pressure the request side.
   always @(posedge clock) begin
      if (reset) begin
         response_bus.ready <= 1'b0;
         stall_left <= 0;
         long_hold_done <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         response_bus.ready <= 1'b0;
      end else if (!long_hold_done && accepted_requests >= LONG_HOLD_AT) begin
         long_hold_done <= 1'b1;
         stall_left <= LONG_HOLD_CYCLES;
         response_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 5);
         response_bus.ready <= 1'b0;
      end else begin
         response_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (!reset && response_bus.valid && response_bus.ready) begin
         seen.physical_address = response_bus.physical_address;
         seen.bytes_left_in_page = response_bus.bytes_left_in_page;
         seen.page_size_code = response_bus.page_size_code;
         seen.status = response_bus.status;
         seen.fault_level = response_bus.fault_level;
         if (expected_translations.size() == 0) begin
            $error("response with no request outstanding: physical_address %h",
                   seen.physical_address);
            error_count++;
         end else begin
            want = expected_translations.pop_front();
            if (seen.physical_address !== want.physical_address) begin
               $error("physical_address: expected %h, actual %h",
                      want.physical_address, seen.physical_address);
               error_count++;
            end
            if (seen.bytes_left_in_page !== want.bytes_left_in_page) begin
               $error("bytes_left_in_page: expected %h, actual %h",
                      want.bytes_left_in_page, seen.bytes_left_in_page);
               error_count++;
            end
            if (seen.page_size_code !== want.page_size_code) begin
               $error("page_size_code: expected %0d, actual %0d",
                      want.page_size_code, seen.page_size_code);
               error_count++;
            end
            if (seen.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, seen.status);
               error_count++;
            end
            if (seen.fault_level !== want.fault_level) begin
               $error("fault_level: expected %0d, actual %0d",
                      want.fault_level, seen.fault_level);
               error_count++;
            end
         end
      end
   end

   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset = 1'b1;
      quiet = 1'b0;
      error_count = 0;
      queued_items = 0;
      accepted_requests = 0;
      root_frame_mirror = '0;
      foreach (table_mirror[i]) table_mirror[i] = '0;
      request_bus.valid = 1'b0;
      request_bus.command = CMD_WRITE;
      request_bus.table_word_index = '0;
      request_bus.table_word_data = '0;
      request_bus.virtual_address = '0;
      response_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Hand-built tables: PML4 in frame 0, PDPT in frame 1, PD in frame 2, PT in frame 3.
      write_root_frame('0);
      queue_translate('0);
      queue_translate('1);
      queue_write('1, '1);
      queue_write(12'd0, 64'hFFFF_0000_0000_1081);
      queue_write(12'd512, 64'h0000_0000_0000_2001);
      queue_write(12'd1024, 64'h0000_0000_0000_3001);
      queue_write(12'd1536, 64'h0000_FFFF_FFFF_F081);
      queue_translate(48'h0000_0000_0000);
      queue_translate(48'h0000_0000_0FFF);
      queue_write(12'd513, 64'h0000_FFFF_FFFF_F081);
      queue_translate(48'h0000_7FFF_FFFF);
      queue_translate(48'h0000_4000_0000);
      queue_write(12'd1025, 64'h0000_8000_0020_0081);
      queue_translate(48'h0000_003F_FFFF);
      queue_translate(48'h0080_0000_0000);
      queue_translate(48'h0000_8000_0000);
      queue_translate(48'h0000_0040_0000);
      queue_translate(48'h0000_0000_1000);
      queue_write(12'd2, 64'h0000_0000_0000_8001);
      queue_translate(48'h0100_0000_0000);
      queue_write(12'd515, 64'h0000_FFFF_FFFF_F001);
      queue_translate(48'h0000_C000_0000);
      queue_write(12'd1027, 64'h0000_0000_0000_9001);
      queue_translate(48'h0000_0060_0000);
      wait_drained();

      // A root table outside the store faults every walk at the top level.
      write_root_frame('1);
      queue_translate('0);
      queue_translate(VA_W'({$urandom, $urandom}));
      queue_write(WIDX_W'($urandom), {$urandom, $urandom});
      wait_drained();

      write_root_frame(FRAME_W'(TABLE_FRAMES - 1));
      queue_random_mix(500, FRAME_W'(TABLE_FRAMES - 1));
      wait_drained();
      write_root_frame(FRAME_W'(3));
      queue_random_mix(500, FRAME_W'(3));
      wait_drained();
      root_frame_mirror = FRAME_W'($urandom_range(0, TABLE_FRAMES - 1));
      write_root_frame(root_frame_mirror);
      queue_random_mix(400, root_frame_mirror);
      wait_drained();
      write_root_frame(FRAME_W'(TABLE_FRAMES));
      queue_random_mix(100, FRAME_W'(TABLE_FRAMES));
      wait_drained();

      quiet = 1'b1;
      write_root_frame('0);
      queue_random_mix(500, '0);
      wait_drained();

      if (error_count == 0 && expected_translations.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
